[src/afd_pkg.sv]
// shared types and constants of the audio frame header deframer
package afd_pkg;

	localparam int BYTE_W         = 8;
	localparam int POS_W          = 6;
	localparam int HDR_DEPTH      = 16;
	localparam int HEADER_BYTES   = 14;
	localparam int TRAILER_BYTES  = 5;
	localparam int OVERFLOW_LIMIT = 255;
	localparam int MONO_PAYLOAD   = 32;
	localparam int AFTER_HDR_MAX  = 127;

	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	// register index is paddr[2]
	localparam logic REG_STEREO_MODE = 1'b0;

	// header bytes, padded with zeros past the header length
	localparam logic [BYTE_W-1:0] HDR_MONO [HDR_DEPTH] = '{
		8'h24, 8'h4B, 8'h49, 8'h54, 8'h52, 8'h41, 8'h2C, 8'h36,
		8'h38, 8'h33, 8'h2C, 8'h33, 8'h32, 8'h2C, 8'h00, 8'h00
	};
	localparam logic [BYTE_W-1:0] HDR_STEREO [HDR_DEPTH] = '{
		8'h24, 8'h4B, 8'h49, 8'h54, 8'h52, 8'h41, 8'h2C, 8'h36,
		8'h38, 8'h33, 8'h2C, 8'h36, 8'h34, 8'h2C, 8'h00, 8'h00
	};

	// drain request from the front part: one per completed frame
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] last_idx;
	} drain_req_t;

endpackage

[src/afd_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module afd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/afd_front.sv]
// front part: header hunt, payload store writes, frame completion
module afd_front #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                stereo_mode,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [afd_pkg::BYTE_W-1:0]          rx_byte,
	input  logic                                back_busy,
	output logic                                ram_we,
	output logic [$clog2(MAX_PAYLOAD)-1:0]      ram_waddr,
	output logic [afd_pkg::BYTE_W-1:0]          ram_wdata,
	output afd_pkg::drain_req_t                 push
);

	import afd_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);

	logic [7:0] bsc_q;
	logic [3:0] hp_q;
	logic       inf_q;
	logic [6:0] bah_q;

	logic       accept;
	logic       ovf;
	logic [7:0] bsc_base;
	logic [3:0] hp_base;
	logic       inf_base;
	logic [6:0] bah_base;
	logic [7:0] hdr_b;
	logic [4:0] p_next;
	logic [6:0] plen;
	logic [7:0] total;
	logic [6:0] bah_inc;
	logic       done;

	// a new frame may not overwrite the store while the last one drains
	assign in_stall = inf_q & back_busy;
	assign accept   = in_valid & ~in_stall;

	assign ovf      = bsc_q >= 8'(OVERFLOW_LIMIT);
	assign bsc_base = ovf ? 8'd0 : bsc_q;
	assign hp_base  = ovf ? 4'd0 : hp_q;
	assign inf_base = ovf ? 1'b0 : inf_q;
	assign bah_base = ovf ? 7'd0 : bah_q;

	assign plen  = stereo_mode ? 7'(MAX_PAYLOAD) : 7'(MONO_PAYLOAD);
	assign total = {1'b0, plen} + 8'(TRAILER_BYTES);

	assign hdr_b = stereo_mode ? HDR_STEREO[hp_base] : HDR_MONO[hp_base];

	always_comb begin
		if (rx_byte == hdr_b) begin
			p_next = {1'b0, hp_base} + 5'd1;
		end else if (rx_byte == HDR_MONO[0]) begin
			p_next = 5'd1;
		end else begin
			p_next = 5'd0;
		end
	end

	assign bah_inc = (bah_base < 7'(AFTER_HDR_MAX)) ? bah_base + 7'd1 : bah_base;
	assign done    = inf_base & ({1'b0, bah_inc} >= total);

	assign ram_we    = accept & inf_base & (bah_base < plen);
	assign ram_waddr = bah_base[AW-1:0];
	assign ram_wdata = rx_byte;

	assign push.valid    = accept & done;
	assign push.last_idx = POS_W'(plen - 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsc_q <= '0;
			hp_q  <= '0;
			inf_q <= 1'b0;
			bah_q <= '0;
		end else if (accept) begin
			if (!inf_base) begin
				bsc_q <= bsc_base + 8'd1;
				bah_q <= bah_base;
				if (p_next >= 5'(HEADER_BYTES)) begin
					hp_q  <= '0;
					inf_q <= 1'b1;
					bah_q <= '0;
				end else begin
					hp_q  <= p_next[3:0];
					inf_q <= 1'b0;
				end
			end else if (done) begin
				bsc_q <= '0;
				hp_q  <= '0;
				inf_q <= 1'b0;
				bah_q <= '0;
			end else begin
				bsc_q <= bsc_base + 8'd1;
				hp_q  <= hp_base;
				inf_q <= 1'b1;
				bah_q <= bah_inc;
			end
		end
	end

endmodule

[src/afd_reqq.sv]
// two-entry queue of drain requests between front and back
module afd_reqq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  afd_pkg::drain_req_t           push,
	input  logic                          pop,
	output logic                          nonempty,
	output logic [afd_pkg::POS_W-1:0]     head_last_idx
);

	import afd_pkg::*;

	logic [POS_W-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign nonempty      = count_q != 2'd0;
	assign head_last_idx = entry_q[rd_ptr_q];
	assign do_push       = push.valid & (count_q != 2'd2);
	assign do_pop        = pop & nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.last_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/afd_back.sv]
// back part: reads the stored payload out as a run of result bytes
module afd_back #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_nonempty,
	input  logic [afd_pkg::POS_W-1:0]      q_last_idx,
	output logic                           q_pop,
	output logic                           busy,
	output logic                           ram_re,
	output logic [$clog2(MAX_PAYLOAD)-1:0] ram_raddr,
	input  logic [afd_pkg::BYTE_W-1:0]     ram_rdata,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [afd_pkg::BYTE_W-1:0]     payload_byte,
	output logic [afd_pkg::POS_W-1:0]      byte_position,
	output logic                           last_of_frame
);

	import afd_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);

	logic              active_q;
	logic [AW-1:0]     cnt_q;
	logic [AW-1:0]     last_q;
	logic              rd_pending_q;
	logic [AW-1:0]     pos_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic [AW-1:0]     pos_q;
	logic              last_q_out;

	logic load_out;
	logic issue;

	assign q_pop     = ~active_q & q_nonempty;
	assign busy      = active_q | q_nonempty;
	assign load_out  = rd_pending_q & (~out_valid_q | ~out_stall);
	// read data register holds while the output register is full and out_stall is high
	assign issue     = active_q & (~rd_pending_q | load_out);
	assign ram_re    = issue;
	assign ram_raddr = cnt_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			last_q <= q_last_idx[AW-1:0];
		end
		if (issue) begin
			pos_s1  <= cnt_q;
			last_s1 <= cnt_q == last_q;
		end
		if (load_out) begin
			byte_q     <= ram_rdata;
			pos_q      <= pos_s1;
			last_q_out <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			cnt_q        <= '0;
			rd_pending_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (issue) begin
				if (cnt_q == last_q) begin
					active_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + AW'(1);
				end
			end
			rd_pending_q <= issue | (rd_pending_q & ~load_out);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = byte_q;
	assign byte_position = POS_W'(pos_q);
	assign last_of_frame = last_q_out;

endmodule

[src/audio_frame_header_deframer.sv]
// top level of the audio frame header deframer
// Takes one received byte per request and hunts for the 14-byte ASCII frame header whose
// channel digits follow stereo_mode (register 0: 0 expects "32" and 32 payload bytes, 1
// expects "64" and 64). When the last trailer byte arrives the stored payload is read out
// of a payload ram with separate write and read ports, one byte per cycle while out_stall
// is low: the drain request passes the request queue, the back part's active flag, the
// ram read data register and the output register before the first byte is valid. The
// final byte is marked by last_of_frame. While that run is still being read out, header
// hunting goes on, but in_stall rises once a new header has been found and stays up
// until the run has left the ram. A count of 255 received bytes drops any partial frame.
// No clearing pass after reset.
module audio_frame_header_deframer #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [afd_pkg::PADDR_W-1:0]   paddr,
	input  logic [afd_pkg::PDATA_W-1:0]   pwdata,
	output logic [afd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [afd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [afd_pkg::BYTE_W-1:0]    payload_byte,
	output logic [afd_pkg::POS_W-1:0]     byte_position,
	output logic                          last_of_frame
);

	import afd_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);

	logic              stereo_mode_q;
	logic              back_busy;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	drain_req_t        push;
	logic              q_pop;
	logic              q_nonempty;
	logic [POS_W-1:0]  q_last_idx;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == REG_STEREO_MODE) begin
			stereo_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_STEREO_MODE) ? {{(PDATA_W-1){1'b0}}, stereo_mode_q}
	                                              : '0;

	afd_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stereo_mode(stereo_mode_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.back_busy  (back_busy),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.push       (push)
	);

	afd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	afd_reqq u_reqq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pop          (q_pop),
		.nonempty     (q_nonempty),
		.head_last_idx(q_last_idx)
	);

	afd_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_last_idx   (q_last_idx),
		.q_pop        (q_pop),
		.busy         (back_busy),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.byte_position(byte_position),
		.last_of_frame(last_of_frame)
	);

endmodule
